[design/ljg_pkg.sv]
// ----------------------------------------------------------------------------
// ljg_pkg - shared types and constants of the lossless jpeg gray decoder
// Operation and result codes, register indexes and the control structs that
// pass between the sequencer, the huffman unit and the reconstruction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ljg_pkg;

  // sizing
  localparam int SYMBOL_SLOTS_DEF = 32;
  localparam int DIM_BITS_DEF     = 16;
  localparam int MAX_CODE_LENGTH  = 16;
  localparam int POS_W            = 13;  // 16 lengths x 255 codes + offset
  localparam int CODE_W           = 17;  // first code of a length, bit 16 sticky

  localparam logic [CODE_W-1:0] CODE_SAT = {1'b1, {(CODE_W-1){1'b0}}};

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREC   = 2'd2;

  localparam logic [15:0] WIDTH_RST   = 16'd512;
  localparam logic [15:0] HEIGHT_RST  = 16'd512;
  localparam logic [4:0]  PREC_RST    = 5'd8;
  localparam logic [4:0]  PREC_NARROW = 5'd8;   // masks samples to 8 bits
  localparam logic [4:0]  PREC_MAX    = 5'd16;

  // stream markers
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] CAT_ZERO = 8'd0;
  localparam logic [7:0] CAT_BIG  = 8'd16;
  localparam logic [15:0] DIFF_BIG = 16'h8000;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_COUNT  = 2'd1,
    OP_SYMBOL = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_MARKER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel;
    logic [7:0]  marker;
    logic        done;
  } res_t;

  // sequencer -> huffman unit
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_in;
  } hcmd_t;

  // huffman unit -> sequencer, valid with step
  typedef struct packed {
    logic hit;
    logic err;
  } hstat_t;

  // sequencer -> reconstruction unit
  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       bit_in;
    logic       load_cat;
    logic [3:0] cat;
    logic       set_diff;
    logic       big;
    logic       mk_diff;
    logic       emit;
  } rcmd_t;

  // reconstruction unit -> sequencer
  typedef struct packed {
    logic        reading;
    logic        extra_last;
    logic [15:0] pixel;
    logic        done;
  } rstat_t;

endpackage

`default_nettype wire

[design/ljg_huff.sv]
// ----------------------------------------------------------------------------
// ljg_huff - bit-serial canonical huffman decoder
// Takes one code bit per step, tracks the first code and symbol base of the
// current length and looks the category up in the symbol memory on a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module ljg_huff
  import ljg_pkg::*;
#(
  parameter int SYMBOL_SLOTS = SYMBOL_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hcmd_t      cmd,
  input  wire logic       cnt_we,
  input  wire logic       sym_we,
  input  wire logic [4:0] wr_slot,
  input  wire logic [7:0] wr_data,
  output hstat_t          stat,
  output logic [7:0]      cat
);

  localparam int AW = $clog2(SYMBOL_SLOTS);

  logic [7:0]        counts_r [MAX_CODE_LENGTH];
  logic [7:0]        sym_mem  [SYMBOL_SLOTS];
  logic [7:0]        cat_r;

  logic [15:0]       accum_r, accum_nxt, acc_sh;
  logic [3:0]        len_r, len_nxt;
  logic [4:0]        len_inc;
  logic [CODE_W-1:0] code_r, code_nxt, off;
  logic [CODE_W:0]   sum;
  logic [CODE_W+1:0] sh;
  logic [POS_W-1:0]  base_r, base_nxt, pos;
  logic [7:0]        cnt;
  logic              match, in_range;

  always_comb begin
    acc_sh   = {accum_r[14:0], cmd.bit_in};
    len_inc  = {1'b0, len_r} + 5'd1;
    cnt      = counts_r[len_r];
    off      = {1'b0, acc_sh} - code_r;
    match    = ({1'b0, acc_sh} >= code_r) && (off < {{(CODE_W-8){1'b0}}, cnt});
    pos      = base_r + POS_W'(off[7:0]);
    in_range = pos < POS_W'(SYMBOL_SLOTS);

    stat.hit = cmd.step && match && in_range;
    stat.err = cmd.step && ((match && !in_range) ||
                            (!match && len_inc >= 5'(MAX_CODE_LENGTH)));

    // next first code, pinned once it leaves the 16-bit code space
    sum = {1'b0, code_r} + {{(CODE_W+1-8){1'b0}}, cnt};
    sh  = {sum, 1'b0};

    accum_nxt = accum_r;
    len_nxt   = len_r;
    code_nxt  = code_r;
    base_nxt  = base_r;
    if (cmd.clear || stat.hit || stat.err) begin
      accum_nxt = '0;
      len_nxt   = '0;
      code_nxt  = '0;
      base_nxt  = '0;
    end else if (cmd.step) begin
      accum_nxt = acc_sh;
      len_nxt   = len_inc[3:0];
      code_nxt  = (|sh[CODE_W+1:CODE_W-1]) ? CODE_SAT : sh[CODE_W-1:0];
      base_nxt  = base_r + POS_W'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      len_r   <= '0;
      code_r  <= '0;
      base_r  <= '0;
    end else begin
      accum_r <= accum_nxt;
      len_r   <= len_nxt;
      code_r  <= code_nxt;
      base_r  <= base_nxt;
    end
  end

  // table storage
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts_r[wr_slot[3:0]] <= wr_data;
    end
    if (sym_we) begin
      sym_mem[AW'(wr_slot)] <= wr_data;
    end
    if (stat.hit) begin
      cat_r <= sym_mem[pos[AW-1:0]];
    end
  end

  assign cat = cat_r;

endmodule

`default_nettype wire

[design/ljg_recon.sv]
// ----------------------------------------------------------------------------
// ljg_recon - extra bits and sample reconstruction
// Shifts in the extra bits of a category, turns them into a signed
// difference, adds the prediction and keeps the row and column position.
// ----------------------------------------------------------------------------
`default_nettype none

module ljg_recon
  import ljg_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rcmd_t       cmd,
  input  wire logic [15:0] width,
  input  wire logic [15:0] height,
  input  wire logic [4:0]  prec,
  output rstat_t           stat
);

  logic [14:0]         buf_r;
  logic [3:0]          cnt_r, cat_r;
  logic                reading_r;
  logic [15:0]         diff_r, left_r, first_r;
  logic [DIM_BITS-1:0] col_r, row_r, col_inc;
  logic [DIM_BITS:0]   row_inc;

  logic        neg, wrap;
  logic [15:0] off16, diff_mk, half, pred, pix_sum, pix;
  logic [4:0]  p_cl;
  logic [3:0]  half_sh;

  always_comb begin
    // jpeg sign rule: top extra bit clear means a negative difference
    neg     = ~buf_r[cat_r - 4'd1];
    off16   = (16'hFFFF << cat_r) + 16'd1;
    diff_mk = neg ? ({1'b0, buf_r} + off16) : {1'b0, buf_r};

    if (prec == 5'd0) begin
      p_cl = 5'd1;
    end else if (prec > PREC_MAX) begin
      p_cl = PREC_MAX;
    end else begin
      p_cl = prec;
    end
    half_sh = 4'(p_cl - 5'd1);
    half    = 16'd1 << half_sh;

    if (col_r != '0) begin
      pred = left_r;
    end else if (row_r != '0) begin
      pred = first_r;
    end else begin
      pred = half;
    end
    pix_sum = pred + diff_r;
    pix     = (prec == PREC_NARROW) ? {8'd0, pix_sum[7:0]} : pix_sum;

    col_inc = col_r + DIM_BITS'(1);
    wrap    = (16'(col_inc) >= width) || (col_inc == '0);
    row_inc = {1'b0, row_r} + (DIM_BITS+1)'(1);

    stat.reading    = reading_r;
    stat.extra_last = reading_r && (({1'b0, cnt_r} + 5'd1) >= {1'b0, cat_r});
    stat.pixel      = pix;
    stat.done       = wrap && (17'(row_inc) >= {1'b0, height});
  end

  // position and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (cmd.clear) begin
      reading_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      if (cmd.load_cat) begin
        reading_r <= 1'b1;
      end
      if (cmd.emit) begin
        reading_r <= 1'b0;
        col_r     <= wrap ? '0 : col_inc;
        if (wrap) begin
          row_r <= row_inc[DIM_BITS-1:0];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      left_r  <= '0;
      first_r <= '0;
    end
    if (cmd.shift) begin
      buf_r <= {buf_r[13:0], cmd.bit_in};
      cnt_r <= cnt_r + 4'd1;
    end
    if (cmd.load_cat) begin
      cat_r <= cmd.cat;
      buf_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.set_diff) begin
      diff_r <= cmd.big ? DIFF_BIG : 16'd0;
    end
    if (cmd.mk_diff) begin
      diff_r <= diff_mk;
    end
    if (cmd.emit) begin
      left_r <= pix;
      if (col_r == '0) begin
        first_r <= pix;
      end
    end
  end

endmodule

`default_nettype wire

[design/lossless_jpeg_gray_decoder.sv]
// ----------------------------------------------------------------------------
// lossless_jpeg_gray_decoder - grayscale lossless jpeg scan decoder
// Loads a canonical huffman table, strips byte stuffing, decodes categories
// one bit per cycle while there is room and rebuilds samples with the left predictor.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tuser: op; tdata: slot_index, byte_value
//  out_     out  tvalid / tready    tuser: kind; tdata: pixel, marker_code,
//                                   image_done; tlast: last
//  cfg_     in   we (no wait)       index, wdata
//
//  a coded byte is shifted through the bit engine one bit per cycle while there
//  is room: accept, bit steps, flush, plus ST_SYM per matched code and ST_PIX
//  (after ST_DIFF if extra bits) per pixel; table loads and scan start are
//  done on acceptance; the bit engine is the limit; it pauses while a result
//  is held and the output register is still full
//  reset is synchronous: registers back to 512 x 512 at 8 bits, scan ended
//  (coded bytes ignored until a start request); tables are not cleared
//
`default_nettype none

module lossless_jpeg_gray_decoder
  import ljg_pkg::*;
#(
  parameter int SYMBOL_SLOTS = SYMBOL_SLOTS_DEF,
  parameter int DIM_BITS     = DIM_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // slot_index[4:0], byte_value[12:5]
  input  wire logic [1:0]            in_tuser,   // op[1:0]
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // pixel[15:0], marker_code[23:16],
                                                 // image_done[24]
  output logic [1:0]                 out_tuser,  // kind[1:0]
  output logic                       out_tlast,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BITS  = 6'b000010,
    ST_SYM   = 6'b000100,
    ST_DIFF  = 6'b001000,
    ST_PIX   = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;

  // configuration registers
  logic [15:0] width_r, height_r;
  logic [4:0]  prec_r;

  // byte shifter and stream state
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic        ff_r, ff_nxt;
  logic        scan_done_r, scan_done_nxt;

  // result held back until it is known whether it is the last of the request
  res_t        hold_r, hold_nxt, push_res;
  logic        hold_vld_r, hold_vld_nxt, push;

  // output register
  res_t        out_res_r, out_res_nxt;
  logic        out_vld_r, out_vld_nxt, out_last_r, out_last_nxt;
  logic        out_free, room;

  // request decode
  logic        in_acc;
  op_t         op;
  logic [4:0]  slot;
  logic [7:0]  bval;

  // sub-unit links
  hcmd_t       hcmd;
  hstat_t      hstat;
  rcmd_t       rcmd;
  rstat_t      rstat;
  logic [7:0]  cat;
  logic        cnt_we, sym_we;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign slot      = in_tdata[4:0];
  assign bval      = in_tdata[12:5];

  assign out_free  = !out_vld_r || out_tready;
  assign room      = !hold_vld_r || out_free;

  ljg_huff #(
    .SYMBOL_SLOTS(SYMBOL_SLOTS)
  ) u_huff (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (hcmd),
    .cnt_we  (cnt_we),
    .sym_we  (sym_we),
    .wr_slot (slot),
    .wr_data (bval),
    .stat    (hstat),
    .cat     (cat)
  );

  ljg_recon #(
    .DIM_BITS(DIM_BITS)
  ) u_recon (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (rcmd),
    .width  (width_r),
    .height (height_r),
    .prec   (prec_r),
    .stat   (rstat)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    bits_nxt      = bits_r;
    ff_nxt        = ff_r;
    scan_done_nxt = scan_done_r;
    hold_nxt      = hold_r;
    hold_vld_nxt  = hold_vld_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    push          = 1'b0;
    push_res      = '{kind: KIND_PIXEL, pixel: 16'd0, marker: 8'd0, done: 1'b0};
    hcmd          = '0;
    rcmd          = '0;
    cnt_we        = 1'b0;
    sym_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_COUNT: begin
              cnt_we = (slot < 5'(MAX_CODE_LENGTH));
            end
            OP_SYMBOL: begin
              sym_we = ({4'd0, slot} < 9'(SYMBOL_SLOTS));
            end
            OP_START: begin
              hcmd.clear    = 1'b1;
              rcmd.clear    = 1'b1;
              ff_nxt        = 1'b0;
              scan_done_nxt = 1'b0;
            end
            OP_BYTE: begin
              if (!scan_done_r) begin
                if (ff_r) begin
                  if (bval == BYTE_00) begin
                    // stuffed ff is plain data
                    ff_nxt    = 1'b0;
                    byte_nxt  = BYTE_FF;
                    bits_nxt  = 4'd8;
                    state_nxt = ST_BITS;
                  end else if (bval != BYTE_FF) begin
                    // marker ends the scan
                    ff_nxt          = 1'b0;
                    scan_done_nxt   = 1'b1;
                    push            = 1'b1;
                    push_res.kind   = KIND_MARKER;
                    push_res.marker = bval;
                    state_nxt       = ST_FLUSH;
                  end
                  // ff after ff is fill, stays held
                end else if (bval == BYTE_FF) begin
                  ff_nxt = 1'b1;
                end else begin
                  byte_nxt  = bval;
                  bits_nxt  = 4'd8;
                  state_nxt = ST_BITS;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_BITS: begin
        if (room) begin
          byte_nxt = {byte_r[6:0], 1'b0};
          bits_nxt = bits_r - 4'd1;
          if (rstat.reading) begin
            rcmd.shift  = 1'b1;
            rcmd.bit_in = byte_r[7];
            if (rstat.extra_last) begin
              state_nxt = ST_DIFF;
            end else if (bits_r == 4'd1) begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            hcmd.step   = 1'b1;
            hcmd.bit_in = byte_r[7];
            if (hstat.hit) begin
              state_nxt = ST_SYM;
            end else if (hstat.err) begin
              scan_done_nxt = 1'b1;
              push          = 1'b1;
              push_res.kind = KIND_ERROR;
              state_nxt     = ST_FLUSH;
            end else if (bits_r == 4'd1) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end

      ST_SYM: begin
        if (room) begin
          if (cat == CAT_ZERO || cat == CAT_BIG) begin
            rcmd.set_diff = 1'b1;
            rcmd.big      = (cat == CAT_BIG);
            state_nxt     = ST_PIX;
          end else if (cat > CAT_BIG) begin
            scan_done_nxt = 1'b1;
            push          = 1'b1;
            push_res.kind = KIND_ERROR;
            state_nxt     = ST_FLUSH;
          end else begin
            rcmd.load_cat = 1'b1;
            rcmd.cat      = cat[3:0];
            state_nxt     = (bits_r == 4'd0) ? ST_FLUSH : ST_BITS;
          end
        end
      end

      ST_DIFF: begin
        rcmd.mk_diff = 1'b1;
        state_nxt    = ST_PIX;
      end

      ST_PIX: begin
        if (room) begin
          rcmd.emit      = 1'b1;
          push           = 1'b1;
          push_res.kind  = KIND_PIXEL;
          push_res.pixel = rstat.pixel;
          push_res.done  = rstat.done;
          if (rstat.done) begin
            // rest of the byte is dropped
            scan_done_nxt = 1'b1;
            state_nxt     = ST_FLUSH;
          end else begin
            state_nxt = (bits_r == 4'd0) ? ST_FLUSH : ST_BITS;
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_res_nxt  = hold_r;
          out_last_nxt = 1'b1;
          out_vld_nxt  = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new result pushes the held one out, not last
    if (push) begin
      if (hold_vld_r) begin
        out_res_nxt  = hold_r;
        out_last_nxt = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      hold_nxt     = push_res;
      hold_vld_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bits_r      <= '0;
      ff_r        <= 1'b0;
      scan_done_r <= 1'b1;
      hold_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_r      <= bits_nxt;
      ff_r        <= ff_nxt;
      scan_done_r <= scan_done_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    hold_r     <= hold_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      prec_r   <= PREC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_PREC:   prec_r   <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r.done, out_res_r.marker, out_res_r.pixel};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[design/ljg_chk.sv]
// ----------------------------------------------------------------------------
// ljg_chk - port checker of the lossless jpeg gray decoder
// Watches the result stream for holding under stall and for the rules on
// which results close a request.
// ----------------------------------------------------------------------------
`default_nettype none

module ljg_chk
  import ljg_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [31:0]           out_tdata,
  input wire logic [1:0]            out_tuser,
  input wire logic                  out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed under stall");

  // marker and error results end the scan, so nothing follows them
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_MARKER || out_tuser == KIND_ERROR) |-> out_tlast)
    else $error("marker or error result not last");

  // non-pixel results carry no sample and no image end
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_MARKER || out_tuser == KIND_ERROR) |->
      out_tdata[15:0] == 16'd0 && !out_tdata[24])
    else $error("stray pixel fields on marker or error");

  // the final pixel of the image closes the request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tlast && out_tuser == KIND_PIXEL)
    else $error("image end not on last pixel result");

endmodule

bind lossless_jpeg_gray_decoder ljg_chk u_ljg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[verif/tb_lossless_jpeg_gray_decoder.sv]
// ----------------------------------------------------------------------------
// tb_lossless_jpeg_gray_decoder - self-checking bench of the gray scan decoder
// Loads canonical huffman tables, sends scans built by a small in-bench
// encoder plus damaged and random streams, and checks every result against
// a bit-level decoder model that runs as each request is accepted.
// ----------------------------------------------------------------------------

module tb_lossless_jpeg_gray_decoder
  import ljg_pkg::*;
();

  localparam int SYM_SLOTS    = SYMBOL_SLOTS_DEF;
  localparam int SETTLE_CYC   = 40;          // room for a coded byte and its results
  localparam int RANDOM_REQS  = 400;
  localparam logic [7:0] EOI_MARK = 8'hD9;

  typedef struct packed {
    op_t        op;
    logic [4:0] slot;
    logic [7:0] val;
  } stream_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel;
    logic [7:0]  marker;
    logic        done;
    logic        last;
  } dec_result_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;    // slot_index[4:0], byte_value[12:5]
  logic [1:0]            in_tuser = '0;    // op[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;        // pixel[15:0], marker_code[23:16], image_done[24]
  logic [1:0]            out_tuser;        // kind[1:0]
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // request stream and the results it should produce
  stream_req_t byte_stream[$];
  stream_req_t cur;
  logic        holding = 1'b0;       // request on the bus, not yet taken
  dec_result_t samples_due[$];
  dec_result_t step_res[$];

  // handshake pressure, in percent of cycles
  int send_gap_pct   = 24;
  int recv_stall_pct = 72;

  int errors  = 0;
  int req_total = 0;
  int n_taken = 0;
  int n_pix = 0, n_mark = 0, n_fault = 0;

  // decoder model: registers, tables and scan state
  logic [15:0] cfg_w = WIDTH_RST;
  logic [15:0] cfg_h = HEIGHT_RST;
  logic [4:0]  cfg_prec = PREC_RST;
  logic [7:0]  m_counts [MAX_CODE_LENGTH];
  logic [7:0]  m_syms   [SYM_SLOTS];
  logic [15:0] xbits = '0;            // extra-bit shifter
  logic [31:0] xcount = '0;
  logic [15:0] code_acc = '0;
  logic [31:0] code_len = '0;
  logic [31:0] cat_pending = '0;
  logic        in_extra = 1'b0;
  logic        ff_held = 1'b0;
  logic [31:0] left_px = '0, first_px = '0, col = '0, rowc = '0;
  logic        scan_over = 1'b1;     // nothing decodes until a start request

  // encoder side: the tables as the stimulus last wrote them
  logic [7:0]  gen_counts [MAX_CODE_LENGTH];
  logic [7:0]  gen_syms   [SYM_SLOTS];
  logic        bit_fifo[$];

  lossless_jpeg_gray_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // decoder model
  // ------------------------------------------------------------------------

  task automatic add_result(input kind_t k, input logic [15:0] pix,
                            input logic [7:0] mk, input logic fin);
    dec_result_t e;
    e.kind   = k;
    e.pixel  = pix;
    e.marker = mk;
    e.done   = fin;
    e.last   = 1'b0;
    step_res.push_back(e);
  endtask

  task automatic clear_bits();
    xbits       = '0;
    xcount      = '0;
    code_acc    = '0;
    code_len    = '0;
    cat_pending = '0;
    in_extra    = 1'b0;
  endtask

  task automatic code_fault();
    add_result(KIND_ERROR, '0, '0, 1'b0);
    clear_bits();
    scan_over = 1'b1;
  endtask

  // canonical match of the bits so far, only at exactly the current length
  function automatic logic code_match(input logic [15:0] acc, input logic [31:0] len,
                                      output logic [31:0] pos);
    logic [31:0] code, base, cnt;
    int l;
    code = '0;
    base = '0;
    pos  = '0;
    for (l = 1; l <= len && l <= MAX_CODE_LENGTH; l++) begin
      cnt = {24'd0, m_counts[l-1]};
      if (l == len) begin
        if (acc >= code && acc - code < cnt) begin
          pos = base + (acc - code);
          return 1'b1;
        end
        return 1'b0;
      end
      code = (code + cnt) << 1;
      base = base + cnt;
    end
    return 1'b0;
  endfunction

  task automatic put_pixel(input logic [31:0] diff);
    logic [31:0] p, pred, mask, pix, nr;
    logic fin;
    p = {27'd0, cfg_prec};
    if (p < 1) p = 1;
    if (p > 16) p = 16;
    // left neighbour, else first pixel of the row above, else mid-range
    if (col > 0) pred = left_px;
    else if (rowc > 0) pred = first_px;
    else pred = 32'd1 << (p - 1);
    mask = (cfg_prec == PREC_NARROW) ? 32'hFF : 32'hFFFF;
    pix = (pred + diff) & mask;
    left_px = pix;
    if (col == 0) first_px = pix;
    col = (col + 1) & 32'hFFFF;
    fin = 1'b0;
    if (col >= cfg_w || col == 0) begin
      col = '0;
      nr  = rowc + 1;
      if (nr >= cfg_h) fin = 1'b1;
      rowc = nr & 32'hFFFF;
    end
    add_result(KIND_PIXEL, pix[15:0], '0, fin);
    clear_bits();
    if (fin) scan_over = 1'b1;
  endtask

  task automatic feed_bit(input logic b);
    logic [31:0] pos, v, c;
    logic [7:0]  cat;
    if (in_extra) begin
      xbits  = {xbits[14:0], b};
      xcount = xcount + 1;
      if (xcount >= cat_pending) begin
        c = cat_pending;
        v = {16'd0, xbits};
        // jpeg sign rule: a leading zero means a negative difference
        if (v < (32'd1 << (c - 1))) v = v - (32'd1 << c) + 1;
        put_pixel(v);
      end
      return;
    end
    code_acc = {code_acc[14:0], b};
    code_len = code_len + 1;
    if (code_match(code_acc, code_len, pos)) begin
      if (pos >= SYM_SLOTS) begin
        code_fault();
        return;
      end
      cat      = m_syms[pos];
      code_acc = '0;
      code_len = '0;
      if (cat == CAT_ZERO) put_pixel(32'd0);
      else if (cat == CAT_BIG) put_pixel({16'd0, DIFF_BIG});
      else if (cat > CAT_BIG) code_fault();
      else begin
        cat_pending = {24'd0, cat};
        in_extra    = 1'b1;
        xbits       = '0;
        xcount      = '0;
      end
    end else if (code_len >= MAX_CODE_LENGTH) begin
      code_fault();
    end
  endtask

  task automatic feed_byte(input logic [7:0] v);
    int i;
    for (i = 7; i >= 0 && !scan_over; i--) feed_bit(v[i]);
  endtask

  // works out what one accepted request produces and queues it
  task automatic model_decode(input stream_req_t r);
    dec_result_t e;
    int k;
    step_res.delete();
    case (r.op)
      OP_COUNT: begin
        if (r.slot < MAX_CODE_LENGTH) m_counts[r.slot[3:0]] = r.val;
      end
      OP_SYMBOL: begin
        if (r.slot < SYM_SLOTS) m_syms[r.slot] = r.val;
      end
      OP_START: begin
        clear_bits();
        ff_held   = 1'b0;
        left_px   = '0;
        first_px  = '0;
        col       = '0;
        rowc      = '0;
        scan_over = 1'b0;
      end
      default: begin
        if (!scan_over) begin
          if (ff_held) begin
            if (r.val == BYTE_00) begin
              ff_held = 1'b0;
              feed_byte(BYTE_FF);
            end else if (r.val != BYTE_FF) begin
              // marker: partial code dropped, scan over
              ff_held = 1'b0;
              clear_bits();
              add_result(KIND_MARKER, '0, r.val, 1'b0);
              scan_over = 1'b1;
            end
          end else if (r.val == BYTE_FF) begin
            ff_held = 1'b1;
          end else begin
            feed_byte(r.val);
          end
        end
      end
    endcase
    for (k = 0; k < step_res.size(); k++) begin
      e = step_res[k];
      e.last = (k == step_res.size() - 1);
      samples_due.push_back(e);
    end
  endtask

  // ------------------------------------------------------------------------
  // driver: presents queued requests, random gaps and back-pressure
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!holding && byte_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        cur     = byte_stream.pop_front();
        holding = 1'b1;
      end
      in_tvalid  <= holding;
      in_tuser   <= cur.op;
      in_tdata   <= {3'b000, cur.val, cur.slot};
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // monitor: runs the model on accepted requests, checks accepted results
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    dec_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        model_decode(cur);
        holding = 1'b0;
        n_taken++;
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        if (samples_due.size() == 0) begin
          $error("result with nothing pending: kind %0d data %0h", out_tuser, out_tdata);
          errors++;
        end else begin
          want = samples_due.pop_front();
          check_field("kind", {14'd0, want.kind}, {14'd0, out_tuser});
          check_field("pixel", want.pixel, out_tdata[15:0]);
          check_field("marker_code", {8'd0, want.marker}, {8'd0, out_tdata[23:16]});
          check_field("image_done", {15'd0, want.done}, {15'd0, out_tdata[24]});
          check_field("last", {15'd0, want.last}, {15'd0, out_tlast});
          case (want.kind)
            KIND_PIXEL:  n_pix++;
            KIND_MARKER: n_mark++;
            default:     n_fault++;
          endcase
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  task automatic queue_req(input op_t op, input logic [4:0] slot, input logic [7:0] val);
    stream_req_t r;
    r.op   = op;
    r.slot = slot;
    r.val  = val;
    byte_stream.push_back(r);
    req_total++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH:  cfg_w    = val;
      REG_HEIGHT: cfg_h    = val;
      REG_PREC:   cfg_prec = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // everything sent, taken and answered, then let any quiet work finish
  task automatic wait_drained(input int settle);
    while (byte_stream.size() != 0 || holding || samples_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // book a: every category 0..16 present, the all-ones 16-bit code unused
  // book b: over 32 symbols, so late positions and wild categories fault
  task automatic load_code_book(input logic book_b);
    int perm [17];
    int i, j, t;
    for (i = 0; i < MAX_CODE_LENGTH; i++) begin
      if (book_b) gen_counts[i] = (i == 1 || i == 2) ? 8'd1 : (i == 7) ? 8'd64 : 8'd0;
      else gen_counts[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'd3 : 8'd1;
      queue_req(OP_COUNT, i[4:0], gen_counts[i]);
    end
    for (i = 0; i < 17; i++) perm[i] = i;
    for (i = 16; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < SYM_SLOTS; i++) begin
      if (!book_b && i < 17) gen_syms[i] = 8'(perm[i]);
      else gen_syms[i] = 8'($urandom_range(255));
      queue_req(OP_SYMBOL, i[4:0], gen_syms[i]);
    end
    // count writes past length 16 go nowhere
    if ($urandom_range(1) == 0)
      queue_req(OP_COUNT, 5'($urandom_range(16, 31)), 8'($urandom_range(255)));
  endtask

  // canonical code of a category in the current book, length 0 if absent
  function automatic int find_code(input int cat, output logic [15:0] code);
    logic [31:0] c, base;
    int l, k;
    c = '0;
    base = '0;
    code = '0;
    for (l = 1; l <= MAX_CODE_LENGTH; l++) begin
      for (k = 0; k < gen_counts[l-1]; k++) begin
        if (base + k < SYM_SLOTS && gen_syms[base+k] == cat) begin
          code = 16'(c + k);
          return l;
        end
      end
      c = (c + gen_counts[l-1]) << 1;
      base = base + gen_counts[l-1];
    end
    return 0;
  endfunction

  task automatic add_symbol(input int cat, input logic [15:0] extra);
    logic [15:0] code;
    int len, i;
    len = find_code(cat, code);
    for (i = len - 1; i >= 0; i--) bit_fifo.push_back(code[i]);
    if (cat >= 1 && cat <= 15)
      for (i = cat - 1; i >= 0; i--) bit_fifo.push_back(extra[i]);
  endtask

  // whole bytes out, ones as padding, stuffing after every ff
  task automatic pack_bytes(input logic pad);
    logic [7:0] b;
    int i;
    while (bit_fifo.size() >= 8 || (pad && bit_fifo.size() > 0)) begin
      for (i = 7; i >= 0; i--) b[i] = (bit_fifo.size() > 0) ? bit_fifo.pop_front() : 1'b1;
      queue_req(OP_BYTE, 5'($urandom_range(31)), b);
      if (b == BYTE_FF) queue_req(OP_BYTE, 5'($urandom_range(31)), BYTE_00);
    end
  endtask

  // one scan: well-formed with random content, or plain random bytes
  task automatic send_scan(input logic noisy);
    int npix, i, cat, junk_at;
    queue_req(OP_START, 5'($urandom_range(31)), 8'($urandom_range(255)));
    if (noisy) begin
      repeat ($urandom_range(3, 8))
        queue_req(OP_BYTE, 5'($urandom_range(31)), 8'($urandom_range(255)));
      return;
    end
    if (cfg_w <= 6 && cfg_h <= 4 && $urandom_range(3) != 0) npix = cfg_w * cfg_h;
    else npix = $urandom_range(2, 9);
    junk_at = ($urandom_range(9) == 0) ? int'($urandom_range(npix - 1)) : -1;
    for (i = 0; i < npix; i++) begin
      cat = ($urandom_range(99) < 65) ? $urandom_range(6) : $urandom_range(16);
      add_symbol(cat, 16'($urandom));
      pack_bytes(1'b0);
      // a stray byte knocks the bit stream out of step
      if (i == junk_at) queue_req(OP_BYTE, 5'($urandom_range(31)), 8'($urandom_range(254)));
    end
    pack_bytes(1'b1);
    case ($urandom_range(3))
      0: ;   // left open, the next start request clears it
      3: begin
        queue_req(OP_BYTE, 5'($urandom_range(31)), BYTE_FF);
        queue_req(OP_BYTE, 5'($urandom_range(31)), BYTE_FF);
        queue_req(OP_BYTE, 5'($urandom_range(31)), 8'($urandom_range(1, 254)));
      end
      default: begin
        queue_req(OP_BYTE, 5'($urandom_range(31)), BYTE_FF);
        queue_req(OP_BYTE, 5'($urandom_range(31)), 8'($urandom_range(1, 254)));
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  initial begin
    int ph, directed_n, rand_n, i;
    logic [15:0] w, h, p;
    for (i = 0; i < MAX_CODE_LENGTH; i++) m_counts[i] = '0;
    for (i = 0; i < SYM_SLOTS; i++) m_syms[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, registers at their reset values
    queue_req(OP_BYTE, 5'd31, 8'hA5);          // no scan open yet: ignored
    queue_req(OP_COUNT, 5'd31, 8'hFF);         // length slot out of range: ignored
    load_code_book(1'b0);
    queue_req(OP_START, 5'd0, 8'h00);
    add_symbol(0, 16'h0000);
    add_symbol(16, 16'h0000);
    add_symbol(15, 16'h0000);                  // most negative difference
    add_symbol(15, 16'h7FFF);                  // most positive difference
    add_symbol(1, 16'h0000);
    add_symbol(1, 16'h0001);
    pack_bytes(1'b1);
    queue_req(OP_BYTE, 5'd0, BYTE_FF);         // fill byte ahead of the marker
    queue_req(OP_BYTE, 5'd31, BYTE_FF);
    queue_req(OP_BYTE, 5'd0, EOI_MARK);
    // sixteen ones match no code: fault
    queue_req(OP_START, 5'd31, 8'hFF);
    repeat (2) begin
      queue_req(OP_BYTE, 5'd0, BYTE_FF);
      queue_req(OP_BYTE, 5'd0, BYTE_00);
    end
    queue_req(OP_BYTE, 5'd0, 8'h00);           // scan ended by the fault: ignored
    directed_n = req_total;

    // random part in phases, each with its own register setting
    ph = 0;
    rand_n = 0;
    while (rand_n < RANDOM_REQS) begin
      wait_drained(SETTLE_CYC);
      if (rand_n < RANDOM_REQS / 3) begin
        send_gap_pct   = 24;
        recv_stall_pct = 72;
      end else if (rand_n < 2 * RANDOM_REQS / 3) begin
        send_gap_pct   = 72;
        recv_stall_pct = 24;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      case (ph)
        0: begin w = 16'd1;     h = 16'd3;     p = 16'd2;  end
        1: begin w = 16'hFFFF;  h = 16'd1;     p = 16'd16; end
        2: begin w = 16'd3;     h = 16'hFFFF;  p = 16'd8;  end
        3: begin w = 16'd2;     h = 16'd2;     p = 16'd16; end
        default: begin
          w = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
          h = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
          p = ($urandom_range(2) == 0) ? 16'd8 : 16'($urandom_range(2, 16));
        end
      endcase
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_PREC, p);
      if (ph > 0 && $urandom_range(5) == 0) begin
        // wide book with random bytes, then back to the regular one
        load_code_book(1'b1);
        send_scan(1'b1);
        send_scan(1'b1);
        load_code_book(1'b0);
      end else if ($urandom_range(4) == 0) begin
        load_code_book(1'b0);
      end
      repeat (3) send_scan($urandom_range(99) < 15);
      ph++;
      rand_n = req_total - directed_n;
    end

    wait_drained(SETTLE_CYC);
    $display("%0d requests taken, %0d results checked: %0d pixels, %0d markers, %0d code faults",
             n_taken, n_pix + n_mark + n_fault, n_pix, n_mark, n_fault);
    $display("%0d register settings visited, %0d mismatches", ph + 1, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
design/ljg_pkg.sv
design/ljg_huff.sv
design/ljg_recon.sv
design/lossless_jpeg_gray_decoder.sv
design/ljg_chk.sv
verif/tb_lossless_jpeg_gray_decoder.sv
